/* rtl/core/kscr_pkg.sv */
package kscr_pkg;

    localparam int ROW_CELLS = 188;
    localparam int IDX_W     = 9;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef logic [15:0] code_t;

    typedef struct packed {
        logic shift;
    } cell_ctrl_t;

    function automatic logic [7:0] cell_to_trail(input logic [7:0] pos);
        logic [7:0] t;
        t = pos + 8'h40;
        if (t >= 8'h7F) begin
            t = t + 8'd1;
        end
        return t;
    endfunction

    function automatic logic [7:0] trail_to_cell(input logic [7:0] trail);
        logic [7:0] c;
        c = trail - 8'h40;
        if (trail > 8'h7F) begin
            c = c - 8'd1;
        end
        return c;
    endfunction

endpackage

/* rtl/core/kscr_cell.sv */
module kscr_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  kscr_pkg::cell_ctrl_t ctrl,
    input  kscr_pkg::code_t     d,
    output kscr_pkg::code_t     q
);
    import kscr_pkg::*;

    code_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (ctrl.shift) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

/* rtl/core/korean_sjis_code_remapper.sv */
// Hangul codes and rejected codes pass from acceptance through ST_WRITE to the output register.
// Table codes (encode and decode) rotate the whole entry ring of USER_ROWS*188 cells once in ST_SCAN first.
// One item is handled at a time; the ring of cells passes one entry per cycle during the scan.
// The input is taken again while a finished result waits at the output register.
// Reset (aresetn low, synchronous) empties every table entry and idles the control.
module korean_sjis_code_remapper #(
    parameter int USER_ROWS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // lead_byte[7:0], trail_byte[15:8]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_lead[7:0], out_trail[15:8]
    output logic        m_tuser    // ok
);
    import kscr_pkg::*;

    localparam int DEPTH = USER_ROWS * ROW_CELLS;
    localparam int CW    = $clog2(DEPTH);

    state_t        state_reg, state_next;
    logic          op_reg, op_next;
    code_t         key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          row_reg, row_next;
    logic [7:0]    col_reg, col_next;
    logic          found_reg, found_next;
    logic          hrow_reg, hrow_next;
    logic [7:0]    hcol_reg, hcol_next;
    code_t         dw_reg, dw_next;
    logic          res_ok_reg, res_ok_next;
    logic [7:0]    res_lead_reg, res_lead_next;
    logic [7:0]    res_trail_reg, res_trail_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [15:0]   m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    logic          accept, need_scan, scan_last, load_out;
    cell_ctrl_t    ctrl;
    code_t         q [DEPTH];
    code_t         tail_in, head;

    logic [7:0]    lead, trail;
    logic          th, dt, hangul, tbl, dhang, duser;
    logic [7:0]    d8, pair_lead, cellh, p8, kl, dcell;
    logic [4:0]    pair;
    logic [IDX_W-1:0] didx;
    logic          imm_ok;
    logic [7:0]    imm_lead, imm_trail;
    logic          hit, dmatch, sel_row;
    logic [7:0]    sel_col;
    code_t         sel_w;

    assign lead  = s_tdata[7:0];
    assign trail = s_tdata[15:8];
    assign head  = q[0];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_ring
            code_t d_in;
            if (gi == DEPTH - 1) begin : g_tail
                assign d_in = tail_in;
            end else begin : g_mid
                assign d_in = q[gi+1];
            end
            kscr_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .d       (d_in),
                .q       (q[gi])
            );
        end
    endgenerate

    // classify and map the direct paths
    always_comb begin
        th     = trail inside {[8'hA1:8'hFE]};
        dt     = trail inside {[8'h40:8'hFE]};
        hangul = (lead inside {[8'hB0:8'hC8]}) && th;
        tbl    = ((lead inside {[8'hA1:8'hAF]}) && th) || ((lead inside {[8'hC9:8'hFE]}) && th)
                 || ((lead inside {[8'h81:8'hC6]}) && (trail inside {[8'h41:8'hFE]}));
        dhang  = ((lead == 8'hEB) || (lead == 8'hEC) || (lead inside {[8'hEF:8'hF9]})) && dt;
        duser  = ((lead == 8'h85) || (lead == 8'h86)) && dt;

        d8   = lead - 8'hB0;
        pair = d8[5:1];
        if (pair == 5'd0) begin
            pair_lead = 8'hEB;
        end else if (pair == 5'd1) begin
            pair_lead = 8'hEC;
        end else begin
            pair_lead = 8'hEF + {3'd0, pair} - 8'd2;
        end
        cellh = (trail - 8'hA1) + (lead[0] ? 8'd94 : 8'd0);

        p8 = lead - 8'hEB;
        if (lead >= 8'hEF) begin
            p8 = p8 - 8'd2;
        end
        kl    = {p8[6:0], 1'b0} + 8'hB0;
        dcell = trail_to_cell(trail);
        if (dcell >= 8'd94) begin
            kl    = kl + 8'd1;
            dcell = dcell - 8'd94;
        end

        didx = ((lead == 8'h86) ? IDX_W'(ROW_CELLS) : '0) + IDX_W'(trail_to_cell(trail));

        imm_ok    = 1'b0;
        imm_lead  = '0;
        imm_trail = '0;
        need_scan = 1'b0;
        if (s_tuser == OP_ENCODE) begin
            if (hangul) begin
                imm_ok    = 1'b1;
                imm_lead  = pair_lead;
                imm_trail = cell_to_trail(cellh);
            end else if (tbl) begin
                need_scan = 1'b1;
            end
        end else begin
            if (dhang) begin
                imm_ok    = 1'b1;
                imm_lead  = kl;
                imm_trail = dcell + 8'hA1;
            end else if (duser && (didx < IDX_W'(DEPTH))) begin
                need_scan = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = need_scan ? ST_SCAN : ST_WRITE;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = 1'b0;
        ctrl.shift = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready   = 1'b1;
            ST_SCAN:  ctrl.shift = 1'b1;
            ST_WRITE: load_out   = !m_tvalid_reg || m_tready;
            default:  s_tready   = 1'b0;
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign scan_last = (state_reg == ST_SCAN) && (cnt_reg == CW'(DEPTH - 1));

    // datapath
    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        found_next     = found_reg;
        hrow_next      = hrow_reg;
        hcol_next      = hcol_reg;
        dw_next        = dw_reg;
        res_ok_next    = res_ok_reg;
        res_lead_next  = res_lead_reg;
        res_trail_next = res_trail_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        hit     = (op_reg == OP_ENCODE) && !found_reg && ((head == key_reg) || (head == '0));
        dmatch  = IDX_W'(cnt_reg) == idx_reg;
        tail_in = hit ? key_reg : head;
        sel_row = found_reg ? hrow_reg : row_reg;
        sel_col = found_reg ? hcol_reg : col_reg;
        sel_w   = dmatch ? head : dw_reg;

        if (accept) begin
            op_next        = s_tuser;
            key_next       = {trail, lead};
            idx_next       = didx;
            cnt_next       = '0;
            row_next       = 1'b0;
            col_next       = '0;
            found_next     = 1'b0;
            dw_next        = '0;
            res_ok_next    = imm_ok;
            res_lead_next  = imm_lead;
            res_trail_next = imm_trail;
        end

        if (state_reg == ST_SCAN) begin
            cnt_next = cnt_reg + CW'(1);
            if (col_reg == 8'(ROW_CELLS - 1)) begin
                col_next = '0;
                row_next = 1'b1;
            end else begin
                col_next = col_reg + 8'd1;
            end
            if (hit) begin
                found_next = 1'b1;
                hrow_next  = row_reg;
                hcol_next  = col_reg;
            end
            if (dmatch) begin
                dw_next = head;
            end
            if (scan_last) begin
                if (op_reg == OP_ENCODE) begin
                    res_ok_next    = found_reg || hit;
                    res_lead_next  = 8'h85 + {7'd0, sel_row};
                    res_trail_next = cell_to_trail(sel_col);
                end else begin
                    res_ok_next    = sel_w != '0;
                    res_lead_next  = sel_w[7:0];
                    res_trail_next = sel_w[15:8];
                end
            end
        end

        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = res_ok_reg;
            m_tdata_next  = res_ok_reg ? {res_trail_reg, res_lead_reg} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        found_reg     <= found_next;
        hrow_reg      <= hrow_next;
        hcol_reg      <= hcol_next;
        dw_reg        <= dw_next;
        res_ok_reg    <= res_ok_next;
        res_lead_reg  <= res_lead_next;
        res_trail_reg <= res_trail_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_scan_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN) || (state_reg == ST_WRITE))
        else $error("scan left to wrong state");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed word carries data");

    a_ring_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0) || $past(state_reg == ST_WRITE)
        || $past(state_reg == ST_IDLE))
        else $error("ring not aligned at idle");

endmodule
